>>> rtl/core/tsk_pkg.sv
package tsk_pkg;

  localparam int TICKET_BITS = 16;
  localparam int CFG_W = 5;
  localparam int MAX_ENTRIES_DEFAULT = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd10;
  localparam logic [TICKET_BITS-1:0] FIRST_TICKET = 16'd1;

  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_LIST = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [TICKET_BITS-1:0] search_ticket;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [TICKET_BITS-1:0] ticket;
    logic last;
  } res_t;

  typedef struct packed {
    logic [1:0] op;
    logic [TICKET_BITS-1:0] key;
  } cmd_t;

endpackage

>>> rtl/core/tsk_front.sv
module tsk_front
  import tsk_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  input  logic q_full,
  output logic q_push,
  output cmd_t q_data
);

  logic held;
  cmd_t cmd;
  logic accept;
  logic known;

  always_comb begin
    unique case (req.req_type)
      REQ_PUSH, REQ_REMOVE, REQ_LIST: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign busy = held && q_full;
  assign accept = start && !busy;
  assign q_push = held && !q_full;
  assign q_data = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      if (q_push) begin
        held <= 1'b0;
      end
      if (accept && known) begin
        held <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && known) begin
      cmd.op <= req.req_type;
      cmd.key <= req.search_ticket;
    end
  end

endmodule

>>> rtl/core/tsk_queue.sv
module tsk_queue
  import tsk_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] fill;
  logic do_push;
  logic do_pop;

  assign full = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

>>> rtl/core/tsk_back.sv
module tsk_back
  import tsk_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             q_empty,
  input  cmd_t             q_data,
  output logic             q_pop,
  output logic             res_valid,
  output res_t             res
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RM_RD  = 7'b0000010,
    S_RM_CMP = 7'b0000100,
    S_SH_RD  = 7'b0001000,
    S_SH_WR  = 7'b0010000,
    S_LS_RD  = 7'b0100000,
    S_LS_OUT = 7'b1000000
  } state_t;

  logic [TICKET_BITS-1:0] mem [MAX_ENTRIES];
  logic [TICKET_BITS-1:0] rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [TICKET_BITS-1:0] mem_wdata;

  state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [TICKET_BITS-1:0] next_ticket, next_ticket_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [TICKET_BITS-1:0] key, key_next;
  logic [CFG_W-1:0] capacity;
  logic out_valid;
  res_t out_res;
  logic is_full;
  logic [CNT_W-1:0] idx_inc;

  assign is_full = (CMP_W'(count) >= CMP_W'(capacity)) ||
                   (CMP_W'(count) >= CMP_W'(MAX_ENTRIES));
  assign idx_inc = CNT_W'(idx) + 1'b1;

  always_comb begin
    state_next = state;
    count_next = count;
    next_ticket_next = next_ticket;
    idx_next = idx;
    key_next = key;
    q_pop = 1'b0;
    out_valid = 1'b0;
    out_res = '0;
    mem_we = 1'b0;
    mem_waddr = idx;
    mem_wdata = rd_data;
    rd_addr = idx;
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          key_next = q_data.key;
          out_res.last = 1'b1;
          case (q_data.op)
            REQ_PUSH: begin
              out_valid = 1'b1;
              if (is_full) begin
                out_res.status = ST_FULL;
              end else begin
                mem_we = 1'b1;
                mem_waddr = IDX_W'(count);
                mem_wdata = next_ticket;
                count_next = count + 1'b1;
                next_ticket_next = next_ticket + 1'b1;
                out_res.status = ST_OK;
                out_res.ticket = next_ticket;
              end
            end
            REQ_REMOVE: begin
              if (count == '0) begin
                out_valid = 1'b1;
                out_res.status = ST_EMPTY;
              end else begin
                idx_next = IDX_W'(count - 1'b1);
                state_next = S_RM_RD;
              end
            end
            default: begin
              if (count == '0) begin
                out_valid = 1'b1;
                out_res.status = ST_EMPTY;
              end else begin
                idx_next = IDX_W'(count - 1'b1);
                state_next = S_LS_RD;
              end
            end
          endcase
        end
      end
      S_RM_RD: begin
        state_next = S_RM_CMP;
      end
      S_RM_CMP: begin
        if (rd_data == key) begin
          state_next = S_SH_RD;
        end else if (idx == '0) begin
          out_valid = 1'b1;
          out_res.status = ST_NOT_FOUND;
          out_res.last = 1'b1;
          state_next = S_IDLE;
        end else begin
          idx_next = idx - 1'b1;
          state_next = S_RM_RD;
        end
      end
      S_SH_RD: begin
        if (idx_inc < count) begin
          rd_addr = IDX_W'(idx_inc);
          state_next = S_SH_WR;
        end else begin
          count_next = count - 1'b1;
          out_valid = 1'b1;
          out_res.status = ST_OK;
          out_res.last = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SH_WR: begin
        mem_we = 1'b1;
        mem_waddr = idx;
        mem_wdata = rd_data;
        idx_next = idx + 1'b1;
        state_next = S_SH_RD;
      end
      S_LS_RD: begin
        state_next = S_LS_OUT;
      end
      S_LS_OUT: begin
        out_valid = 1'b1;
        out_res.status = ST_OK;
        out_res.ticket = rd_data;
        out_res.last = (idx == '0);
        if (idx == '0) begin
          state_next = S_IDLE;
        end else begin
          idx_next = idx - 1'b1;
          state_next = S_LS_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      next_ticket <= FIRST_TICKET;
      capacity <= CAPACITY_RESET;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      next_ticket <= next_ticket_next;
      res_valid <= out_valid;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    key <= key_next;
    res <= out_res;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/ticket_stack_with_keyed_removal.sv
// push and empty results pass the front's held command, the command queue and the
// registered result; remove scans from the top, a read and a compare state per entry,
// then shifts the newer entries down, a read and a write state each; list emits the
// tickets newest first. a two-deep command queue lets start be taken while the back end
// works. results are strobed for one cycle and cannot be stalled.
// reset: store empty, next ticket 1, capacity 10; stored tickets undefined until written
module ticket_stack_with_keyed_removal
  import tsk_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             req,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output logic             res_valid,
  output res_t             res
);

  logic q_push;
  cmd_t q_in;
  logic q_full;
  logic q_pop;
  cmd_t q_out;
  logic q_empty;

  tsk_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  tsk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  tsk_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

>>> dv/tb_ticket_stack_with_keyed_removal.sv
`timescale 1ns / 100ps

module tb_ticket_stack_with_keyed_removal;
  import tsk_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASE_ITEMS = 110;
  localparam int REQ_W = $bits(req_t);

  // model of the ticket stack; held[0] is the oldest ticket
  class ticket_board;
    logic [TICKET_BITS-1:0] held[$];
    logic [CFG_W-1:0] capacity;
    logic [TICKET_BITS-1:0] next_ticket;
    res_t pending[$];
    int errors;
    int items;
    int results;
    int fulls;
    int misses;

    function new();
      capacity = CAPACITY_RESET;
      next_ticket = FIRST_TICKET;
    endfunction

    function void report(string msg);
      errors++;
      $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function void add_result(logic [1:0] st, logic [TICKET_BITS-1:0] tk, logic lst);
      res_t r;
      r.status = st;
      r.ticket = tk;
      r.last = lst;
      pending.push_back(r);
    endfunction

    function void note_request(req_t r);
      int lim;
      int i;
      int hit;
      items++;
      case (r.req_type)
        REQ_PUSH: begin
          lim = (capacity > MAX_ENTRIES_DEFAULT) ? MAX_ENTRIES_DEFAULT : int'(capacity);
          if (held.size() >= lim) begin
            add_result(ST_FULL, '0, 1'b1);
          end else begin
            held.push_back(next_ticket);
            add_result(ST_OK, next_ticket, 1'b1);
            next_ticket = next_ticket + 1'b1;
          end
        end
        REQ_REMOVE: begin
          if (held.size() == 0) begin
            add_result(ST_EMPTY, '0, 1'b1);
          end else begin
            hit = -1;
            for (i = held.size() - 1; i >= 0; i--) begin
              if (hit < 0 && held[i] == r.search_ticket) hit = i;
            end
            if (hit >= 0) begin
              held.delete(hit);
              add_result(ST_OK, '0, 1'b1);
            end else begin
              add_result(ST_NOT_FOUND, '0, 1'b1);
            end
          end
        end
        REQ_LIST: begin
          if (held.size() == 0) begin
            add_result(ST_EMPTY, '0, 1'b1);
          end else begin
            for (i = held.size() - 1; i >= 0; i--) begin
              add_result(ST_OK, held[i], i == 0);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result status %0d ticket %0d last %0d",
                         got.status, got.ticket, got.last));
        return;
      end
      want = pending.pop_front();
      results++;
      if (want.status == ST_FULL) fulls++;
      if (want.status == ST_NOT_FOUND) misses++;
      if (got.status !== want.status) begin
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      end
      if (got.ticket !== want.ticket) begin
        report($sformatf("ticket %0d, expected %0d", got.ticket, want.ticket));
      end
      if (got.last !== want.last) begin
        report($sformatf("last %0d, expected %0d", got.last, want.last));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic res_valid;
  res_t res;

  ticket_board board = new();

  ticket_stack_with_keyed_removal u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .res_valid(res_valid),
    .res      (res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && res_valid) board.check_result(res);
  end

  function automatic req_t mk(logic [1:0] op, logic [TICKET_BITS-1:0] key);
    req_t r;
    r.req_type = op;
    r.search_ticket = key;
    return r;
  endfunction

  function automatic req_t random_item();
    int pick;
    req_t r;
    r.search_ticket = TICKET_BITS'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.req_type = REQ_PUSH;
    end else if (pick < 75) begin
      r.req_type = REQ_REMOVE;
      if (board.held.size() > 0) begin
        r.search_ticket = board.held[$urandom_range(0, board.held.size() - 1)];
      end
    end else if (pick < 82) begin
      r.req_type = REQ_REMOVE;
    end else if (pick < 96) begin
      r.req_type = REQ_LIST;
    end else begin
      r.req_type = REQ_NONE;
    end
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_item(req_t r);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    board.note_request(r);
    @(negedge clk);
  endtask

  task automatic idle_gap(int pct);
    while ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      req <= req_t'(REQ_W'($urandom));
      @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_capacity(logic [CFG_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.capacity = v;
  endtask

  task automatic run_phase(logic [CFG_W-1:0] cap, int pct);
    int k;
    set_capacity(cap);
    for (k = 0; k < PHASE_ITEMS; k++) begin
      if (k % 40 < 28) idle_gap(pct);
      send_item(random_item());
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty store, fill past the reset capacity, keyed removals, ignored type, capacity 0
    send_item(mk(REQ_LIST, '1));
    send_item(mk(REQ_REMOVE, '0));
    repeat (11) send_item(mk(REQ_PUSH, TICKET_BITS'($urandom)));
    send_item(mk(REQ_LIST, '0));
    send_item(mk(REQ_REMOVE, 16'd10));
    send_item(mk(REQ_REMOVE, 16'd5));
    send_item(mk(REQ_REMOVE, 16'd1));
    send_item(mk(REQ_REMOVE, '1));
    send_item(mk(REQ_NONE, '0));
    send_item(mk(REQ_NONE, '1));
    send_item(mk(REQ_LIST, '1));
    set_capacity('0);
    send_item(mk(REQ_PUSH, '1));
    send_item(mk(REQ_LIST, '0));

    run_phase(5'd31, 0);
    run_phase(5'd1, 45);
    run_phase(5'd17, 0);
    run_phase(5'd16, 23);
    drain();

    $display("%0d requests, %0d results checked (%0d full, %0d not found)",
             board.items, board.results, board.fulls, board.misses);
    $display("capacities 0, 1, 10, 16, 17 and 31 incl. saturation, with and without sender gaps");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #64_000_000;
    $display("timeout with %0d results outstanding", board.pending.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
